FILE: hdl/cfd_pkg.sv
// Shared types, constants and lookup functions for the framed-stream deframer.
// Used by every module of the block; depends on nothing.
package cfd_pkg;

    localparam int SYNC_LEN  = 7;
    localparam int HEAD_LEN  = 24;
    localparam int TAIL_LEN  = 8;
    localparam int MIN_FRAME = 32;

    localparam logic [15:0] MAX_FRAME  = 16'd1024;
    localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [7:0]  SYNC_FIRST = 8'h4E;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TAIL    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_TAIL = 2'd1,
        ST_CRC_BAD = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_out_kind;

    // Sync word 4E 41 56 49 41 49 FF, indexed by match progress.
    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h4E;
            3'd1:    v = 8'h41;
            3'd2:    v = 8'h56;
            3'd3:    v = 8'h49;
            3'd4:    v = 8'h41;
            3'd5:    v = 8'h49;
            3'd6:    v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Tail word 54 45 4C 45 4F 50 54 4E, indexed by tail position.
    function automatic logic [7:0] tail_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h54;
            3'd1: v = 8'h45;
            3'd2: v = 8'h4C;
            3'd3: v = 8'h45;
            3'd4: v = 8'h4F;
            3'd5: v = 8'h50;
            3'd6: v = 8'h54;
            3'd7: v = 8'h4E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/cfd_crc_byte.sv
// One byte step of the reflected CRC-32C update.
// Depends on cfd_pkg for the polynomial.
module cfd_crc_byte
    import cfd_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

FILE: hdl/cfd_time_widen.sv
// Widens the 32-bit sender time to 64 bits, nearest to the current time.
// Depends on cfd_pkg only through the common import.
module cfd_time_widen
    import cfd_pkg::*;
(
    input  logic [63:0] i_now,
    input  logic [31:0] i_low,
    output logic [63:0] o_wide
);

    logic [32:0] delta;
    logic [31:0] hi;
    logic        far_above;
    logic        far_below;
    logic [31:0] hi_sel;

    // Within one epoch the nearest candidate is decided by the signed low-half
    // difference alone; a candidate epoch that wraps past either end of the
    // 64-bit range is always farther, so it is never chosen.
    assign delta     = {1'b0, i_low} - {1'b0, i_now[31:0]};
    assign hi        = i_now[63:32];
    assign far_above = ~delta[32] & delta[31] & (|delta[30:0]);
    assign far_below = delta[32] & ~delta[31];

    always_comb begin
        if (far_above && (hi != 32'd0)) begin
            hi_sel = hi - 32'd1;
        end else if (far_below && (hi != 32'hFFFF_FFFF)) begin
            hi_sel = hi + 32'd1;
        end else begin
            hi_sel = hi;
        end
    end

    assign o_wide = {hi_sel, i_low};

endmodule

FILE: hdl/crc_checked_frame_deframer.sv
// A byte accepted into the input register is processed once the output register
// can take its result, and any result it yields is registered there for the output.
// Throughput: one byte per cycle while the result side does not stall, set by the
// byte-wide CRC step and the header capture logic between the input and result registers.
// Reset is synchronous and active low; it returns the block to sync search with
// an empty pipeline and clears the CRC failure count. No clearing pass is needed.
module crc_checked_frame_deframer
    import cfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic [63:0] i_now_time,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_last,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_packet_kind,
    output logic [15:0] o_packet_number,
    output logic [15:0] o_fragment_count,
    output logic [15:0] o_fragment_index,
    output logic [63:0] o_sender_time,
    output logic [31:0] o_crc_fail_total
);

    // One result item as it is held in the output register.
    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  payload_byte;
        logic        last;
        t_status     status;
        logic [7:0]  packet_kind;
        logic [15:0] packet_number;
        logic [15:0] fragment_count;
        logic [15:0] fragment_index;
        logic [63:0] sender_time;
        logic [31:0] crc_fail_total;
    } t_result;

    // Input register. Every transfer lands here first; it is processed once the
    // result register can take whatever it produces.
    logic        r_in_valid;
    logic [7:0]  r_rx;
    logic [63:0] r_now;

    // Frame state.
    t_phase      r_phase, n_phase;
    logic [2:0]  r_sync_prog, n_sync_prog;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_hdr_kind, n_hdr_kind;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_body_end, n_body_end;
    logic [15:0] r_hdr_number, n_hdr_number;
    logic [15:0] r_hdr_count, n_hdr_count;
    logic [15:0] r_hdr_index, n_hdr_index;
    logic [31:0] r_time_low, n_time_low;
    logic [31:0] r_hdr_crc, n_hdr_crc;
    logic [31:0] r_crc, n_crc;
    logic        r_tail_ok, n_tail_ok;
    logic [31:0] r_crc_fail, n_crc_fail;

    // Result register.
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        n_out_valid;

    logic        advance;
    logic        proc;
    logic        sync_match;
    logic        sync_hit;
    logic [15:0] len_full;
    logic        len_bad;
    logic [2:0]  tail_idx;
    logic        tail_match;
    logic        tail_last;
    logic [15:0] pos_inc;
    logic [31:0] crc_step;
    logic [63:0] wide_time;

    // The stored byte moves on when the result register is empty or is being
    // emptied in this cycle; this lets a new byte enter every cycle without a stall.
    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_rx  <= i_rx_byte;
            r_now <= i_now_time;
        end
    end

    cfd_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_data (r_rx),
        .o_crc  (crc_step)
    );

    cfd_time_widen u_widen (
        .i_now  (r_now),
        .i_low  (r_time_low),
        .o_wide (wide_time)
    );

    // Shared decode of the byte in the input register.
    assign sync_match = (r_rx == sync_byte(r_sync_prog));
    assign sync_hit   = sync_match && (r_sync_prog == 3'(SYNC_LEN - 1));
    // The second length byte completes the frame length together with the low byte.
    assign len_full   = {r_rx, r_len_lo};
    assign len_bad    = (len_full < 16'(MIN_FRAME)) || (len_full > MAX_FRAME);
    // The tail always starts at body_end, so the low bits give the tail index,
    // and the eighth tail byte is the last byte of the frame.
    assign tail_idx   = 3'(r_pos - r_body_end);
    assign tail_match = (r_rx == tail_byte(tail_idx));
    assign tail_last  = (tail_idx == 3'(TAIL_LEN - 1));
    assign pos_inc    = r_pos + 16'd1;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (proc) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (sync_hit) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if ((r_pos == 16'd9) && len_bad) begin
                        n_phase = PH_SEARCH;
                    end else if (r_pos == 16'(HEAD_LEN - 1)) begin
                        n_phase = (r_body_end == 16'(HEAD_LEN)) ? PH_TAIL : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (pos_inc == r_body_end) begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (tail_last) begin
                        n_phase = PH_SEARCH;
                    end
                end
            endcase
        end
    end

    // Datapath updates and the result item.
    always_comb begin
        logic tail_ok_now;
        logic crc_bad;

        n_sync_prog  = r_sync_prog;
        n_pos        = r_pos;
        n_hdr_kind   = r_hdr_kind;
        n_len_lo     = r_len_lo;
        n_body_end   = r_body_end;
        n_hdr_number = r_hdr_number;
        n_hdr_count  = r_hdr_count;
        n_hdr_index  = r_hdr_index;
        n_time_low   = r_time_low;
        n_hdr_crc    = r_hdr_crc;
        n_crc        = r_crc;
        n_tail_ok    = r_tail_ok;
        n_crc_fail   = r_crc_fail;
        n_out_valid  = 1'b0;
        n_out        = '0;
        tail_ok_now  = r_tail_ok && tail_match;
        crc_bad      = ((r_crc ^ CRC_INIT) != r_hdr_crc);

        if (proc) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (sync_hit) begin
                        // Full sync word seen: start a fresh frame.
                        n_sync_prog  = 3'd0;
                        n_pos        = 16'(SYNC_LEN);
                        n_hdr_kind   = 8'd0;
                        n_len_lo     = 8'd0;
                        n_body_end   = 16'd0;
                        n_hdr_number = 16'd0;
                        n_hdr_count  = 16'd0;
                        n_hdr_index  = 16'd0;
                        n_time_low   = 32'd0;
                        n_hdr_crc    = 32'd0;
                        n_crc        = CRC_INIT;
                        n_tail_ok    = 1'b1;
                    end else if (sync_match) begin
                        n_sync_prog = r_sync_prog + 3'd1;
                    end else begin
                        // The sync word has no self-overlap, so a mismatch only
                        // needs to check for a fresh first byte.
                        n_sync_prog = (r_rx == SYNC_FIRST) ? 3'd1 : 3'd0;
                    end
                end
                PH_HEADER: begin
                    n_pos = pos_inc;
                    unique case (r_pos[4:0])
                        5'd7:  n_hdr_kind = r_rx;
                        5'd8:  n_len_lo = r_rx;
                        5'd9:  n_body_end = len_full - 16'(TAIL_LEN);
                        5'd10: n_hdr_number[7:0] = r_rx;
                        5'd11: n_hdr_number[15:8] = r_rx;
                        5'd12: n_hdr_count[7:0] = r_rx;
                        5'd13: n_hdr_count[15:8] = r_rx;
                        5'd14: n_hdr_index[7:0] = r_rx;
                        5'd15: n_hdr_index[15:8] = r_rx;
                        5'd16, 5'd17, 5'd18, 5'd19:
                            n_time_low[8*r_pos[1:0] +: 8] = r_rx;
                        5'd20, 5'd21, 5'd22, 5'd23:
                            n_hdr_crc[8*r_pos[1:0] +: 8] = r_rx;
                        default: ;
                    endcase
                    if ((r_pos == 16'd9) && len_bad) begin
                        // A bad length ends the frame right away.
                        n_sync_prog              = 3'd0;
                        n_pos                    = 16'd0;
                        n_out_valid              = 1'b1;
                        n_out.kind               = KIND_STATUS;
                        n_out.last               = 1'b1;
                        n_out.status             = ST_BAD_LEN;
                        n_out.packet_kind        = r_hdr_kind;
                        n_out.crc_fail_total     = r_crc_fail;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc              = crc_step;
                    n_pos              = pos_inc;
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_PAYLOAD;
                    n_out.payload_byte = r_rx;
                end
                PH_TAIL: begin
                    n_pos     = pos_inc;
                    n_tail_ok = tail_ok_now;
                    if (tail_last) begin
                        n_sync_prog          = 3'd0;
                        n_pos                = 16'd0;
                        n_out_valid          = 1'b1;
                        n_out.kind           = KIND_STATUS;
                        n_out.last           = 1'b1;
                        n_out.packet_kind    = r_hdr_kind;
                        n_out.packet_number  = r_hdr_number;
                        n_out.fragment_count = r_hdr_count;
                        n_out.fragment_index = r_hdr_index;
                        n_out.sender_time    = wide_time;
                        // A bad tail wins over a CRC mismatch and is not counted.
                        if (!tail_ok_now) begin
                            n_out.status = ST_BAD_TAIL;
                        end else if (crc_bad) begin
                            n_crc_fail   = r_crc_fail + 32'd1;
                            n_out.status = ST_CRC_BAD;
                        end else begin
                            n_out.status = ST_OK;
                        end
                        n_out.crc_fail_total = n_crc_fail;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_sync_prog  <= 3'd0;
            r_pos        <= 16'd0;
            r_hdr_kind   <= 8'd0;
            r_len_lo     <= 8'd0;
            r_body_end   <= 16'd0;
            r_hdr_number <= 16'd0;
            r_hdr_count  <= 16'd0;
            r_hdr_index  <= 16'd0;
            r_time_low   <= 32'd0;
            r_hdr_crc    <= 32'd0;
            r_crc        <= CRC_INIT;
            r_tail_ok    <= 1'b1;
            r_crc_fail   <= 32'd0;
        end else begin
            r_phase      <= n_phase;
            r_sync_prog  <= n_sync_prog;
            r_pos        <= n_pos;
            r_hdr_kind   <= n_hdr_kind;
            r_len_lo     <= n_len_lo;
            r_body_end   <= n_body_end;
            r_hdr_number <= n_hdr_number;
            r_hdr_count  <= n_hdr_count;
            r_hdr_index  <= n_hdr_index;
            r_time_low   <= n_time_low;
            r_hdr_crc    <= n_hdr_crc;
            r_crc        <= n_crc;
            r_tail_ok    <= n_tail_ok;
            r_crc_fail   <= n_crc_fail;
        end
    end

    // The result register is refilled whenever a processed byte yields a result;
    // otherwise it empties once its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_frame_last     = r_out.last;
    assign o_frame_status   = r_out.status;
    assign o_packet_kind    = r_out.packet_kind;
    assign o_packet_number  = r_out.packet_number;
    assign o_fragment_count = r_out.fragment_count;
    assign o_fragment_index = r_out.fragment_index;
    assign o_sender_time    = r_out.sender_time;
    assign o_crc_fail_total = r_out.crc_fail_total;

    // The failure count only moves together with a freshly loaded CRC-mismatch
    // status that reports the new count.
    a_crc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_crc_fail != $past(r_crc_fail))) |->
        (o_out_valid && (o_frame_status == ST_CRC_BAD) && (o_crc_fail_total == r_crc_fail)))
        else $error("CRC failure count changed without a CRC mismatch status");

    // Sync progress is only meaningful while searching.
    a_sync_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEARCH) |-> (r_sync_prog == 3'd0))
        else $error("sync progress left nonzero outside of search");

    // While in the tail the position stays within the eight tail bytes.
    a_tail_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAIL) |-> ((r_pos - r_body_end) < 16'(TAIL_LEN)))
        else $error("tail position ran past the tail word");

endmodule

FILE: tb/cfd_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the CRC-checked frame deframer. It predicts every result from the
// input transfers and compares it with the output transfers. Depends on cfd_pkg.
module cfd_result_checker
    import cfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic [63:0] i_now_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_out_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_frame_last,
    input  logic [1:0]  i_frame_status,
    input  logic [7:0]  i_packet_kind,
    input  logic [15:0] i_packet_number,
    input  logic [15:0] i_fragment_count,
    input  logic [15:0] i_fragment_index,
    input  logic [63:0] i_sender_time,
    input  logic [31:0] i_crc_fail_total,
    output int          o_pending,
    output int          o_fail_count
);

    localparam logic [55:0] SYNC_WORD  = 56'h4E41_5649_4149_FF;
    localparam logic [63:0] TAIL_WORD  = 64'h5445_4C45_4F50_544E;
    localparam logic [31:0] CASTAGNOLI = 32'h82F6_3B78;
    localparam int          MAX_REPORTS = 50;

    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  data;
        logic        last;
        t_status     status;
        logic [7:0]  pkt_kind;
        logic [15:0] pkt_number;
        logic [15:0] frag_count;
        logic [15:0] frag_index;
        logic [63:0] sent_at;
        logic [31:0] crc_errors;
    } t_frame_result;

    // Shadow copy of the deframer state.
    logic [2:0]  sync_count;
    t_phase      stage;
    logic [15:0] offset;
    logic [7:0]  h_kind;
    logic [15:0] h_len;
    logic [15:0] h_num;
    logic [15:0] h_cnt;
    logic [15:0] h_idx;
    logic [31:0] h_time;
    logic [31:0] h_crc;
    logic [31:0] crc_acc;
    logic        tail_good;
    logic [31:0] crc_error_cnt;

    t_frame_result predicted_q[$];
    int            mismatches;
    int            results_seen;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch on result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : track
        t_frame_result want;
        t_frame_result pred;
        logic [7:0]    b;
        logic [15:0]   at;
        logic [15:0]   tail_pos;
        logic [63:0]   base;
        logic [63:0]   c_same;
        logic [63:0]   c_next;
        logic [63:0]   c_prev;
        logic [63:0]   d_same;
        logic [63:0]   d_next;
        logic [63:0]   d_prev;
        logic          emit;

        if (!i_rst_n) begin
            sync_count    = '0;
            stage         = PH_SEARCH;
            offset        = '0;
            h_kind        = '0;
            h_len         = '0;
            h_num         = '0;
            h_cnt         = '0;
            h_idx         = '0;
            h_time        = '0;
            h_crc         = '0;
            crc_acc       = 32'hFFFF_FFFF;
            tail_good     = 1'b1;
            crc_error_cnt = '0;
            predicted_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0b", i_out_kind));
                end else begin
                    want = predicted_q.pop_front();
                    check_field("kind", i_out_kind, want.kind);
                    check_field("payload", i_payload_byte, want.data);
                    check_field("last", i_frame_last, want.last);
                    check_field("status", i_frame_status, want.status);
                    check_field("packet kind", i_packet_kind, want.pkt_kind);
                    check_field("packet number", i_packet_number, want.pkt_number);
                    check_field("fragment count", i_fragment_count, want.frag_count);
                    check_field("fragment index", i_fragment_index, want.frag_index);
                    check_field("sender time", i_sender_time, want.sent_at);
                    check_field("crc error count", i_crc_fail_total, want.crc_errors);
                end
                results_seen++;
            end

            if (i_in_valid && !i_in_stall) begin
                b    = i_rx_byte;
                at   = offset;
                emit = 1'b0;
                pred = '0;
                case (stage)
                    PH_SEARCH: begin
                        // The sync word has no self-overlap, so a miss restarts the hunt,
                        // keeping the byte only if it is itself a first sync byte.
                        if (b == SYNC_WORD[8 * (6 - int'(sync_count)) +: 8])
                            sync_count = sync_count + 3'd1;
                        else
                            sync_count = (b == SYNC_WORD[55:48]) ? 3'd1 : 3'd0;
                        if (sync_count == 3'(SYNC_LEN)) begin
                            h_kind     = '0;
                            h_len      = '0;
                            h_num      = '0;
                            h_cnt      = '0;
                            h_idx      = '0;
                            h_time     = '0;
                            h_crc      = '0;
                            crc_acc    = 32'hFFFF_FFFF;
                            tail_good  = 1'b1;
                            stage      = PH_HEADER;
                            offset     = 16'(SYNC_LEN);
                            sync_count = '0;
                        end
                    end
                    PH_HEADER: begin
                        case (at)
                            16'd7:  h_kind       = b;
                            16'd8:  h_len[7:0]   = b;
                            16'd9:  h_len[15:8]  = b;
                            16'd10: h_num[7:0]   = b;
                            16'd11: h_num[15:8]  = b;
                            16'd12: h_cnt[7:0]   = b;
                            16'd13: h_cnt[15:8]  = b;
                            16'd14: h_idx[7:0]   = b;
                            16'd15: h_idx[15:8]  = b;
                            16'd16, 16'd17, 16'd18, 16'd19:
                                h_time[8 * (int'(at) - 16) +: 8] = b;
                            16'd20, 16'd21, 16'd22, 16'd23:
                                h_crc[8 * (int'(at) - 20) +: 8] = b;
                            default: ;
                        endcase
                        offset = at + 16'd1;
                        if (at == 16'd9 && (h_len < 16'(MIN_FRAME) || h_len > MAX_FRAME)) begin
                            // A bad length is reported right away with only the type byte.
                            pred.kind       = KIND_STATUS;
                            pred.last       = 1'b1;
                            pred.status     = ST_BAD_LEN;
                            pred.pkt_kind   = h_kind;
                            pred.crc_errors = crc_error_cnt;
                            emit            = 1'b1;
                            stage           = PH_SEARCH;
                            sync_count      = '0;
                            offset          = '0;
                        end else if (offset >= 16'(HEAD_LEN)) begin
                            stage = (offset >= h_len - 16'(TAIL_LEN)) ? PH_TAIL : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        crc_acc = crc_acc ^ {24'h0, b};
                        for (int k = 0; k < 8; k++)
                            crc_acc = crc_acc[0] ? (crc_acc >> 1) ^ CASTAGNOLI : crc_acc >> 1;
                        offset = at + 16'd1;
                        if (offset >= h_len - 16'(TAIL_LEN))
                            stage = PH_TAIL;
                        pred.kind = KIND_PAYLOAD;
                        pred.data = b;
                        emit      = 1'b1;
                    end
                    PH_TAIL: begin
                        tail_pos = at - (h_len - 16'(TAIL_LEN));
                        if (tail_pos >= 16'(TAIL_LEN) ||
                            b != TAIL_WORD[8 * (7 - int'(tail_pos[2:0])) +: 8])
                            tail_good = 1'b0;
                        offset = at + 16'd1;
                        if (offset >= h_len) begin
                            // A bad tail wins over a CRC error and leaves the count alone.
                            if (!tail_good) begin
                                pred.status = ST_BAD_TAIL;
                            end else if ((crc_acc ^ 32'hFFFF_FFFF) != h_crc) begin
                                crc_error_cnt = crc_error_cnt + 32'd1;
                                pred.status   = ST_CRC_BAD;
                            end else begin
                                pred.status = ST_OK;
                            end
                            // Widen the 32-bit sender time to the candidate epoch nearest
                            // to now; ties favor the same epoch, then the next one.
                            base   = {i_now_time[63:32], 32'h0};
                            c_same = base | {32'h0, h_time};
                            c_next = (base + 64'h1_0000_0000) | {32'h0, h_time};
                            c_prev = (base - 64'h1_0000_0000) | {32'h0, h_time};
                            d_same = (c_same > i_now_time) ? c_same - i_now_time
                                                           : i_now_time - c_same;
                            d_next = (c_next > i_now_time) ? c_next - i_now_time
                                                           : i_now_time - c_next;
                            d_prev = (c_prev > i_now_time) ? c_prev - i_now_time
                                                           : i_now_time - c_prev;
                            if (d_same <= d_next && d_same <= d_prev)
                                pred.sent_at = c_same;
                            else if (d_next <= d_same && d_next <= d_prev)
                                pred.sent_at = c_next;
                            else
                                pred.sent_at = c_prev;
                            pred.kind       = KIND_STATUS;
                            pred.last       = 1'b1;
                            pred.pkt_kind   = h_kind;
                            pred.pkt_number = h_num;
                            pred.frag_count = h_cnt;
                            pred.frag_index = h_idx;
                            pred.crc_errors = crc_error_cnt;
                            emit            = 1'b1;
                            stage           = PH_SEARCH;
                            sync_count      = '0;
                            offset          = '0;
                        end
                    end
                    default: ;
                endcase
                if (emit)
                    predicted_q.insert(predicted_q.size(), pred);
            end
        end
        o_pending    <= predicted_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/tb_crc_checked_frame_deframer.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, a byte stream built from random frames,
// result-side stalls and the verdict. Depends on cfd_pkg, cfd_result_checker and the block.
module tb_crc_checked_frame_deframer;
    import cfd_pkg::*;

    // The random part stops once both the byte goal and the frame count are met.
    localparam int ITEM_GOAL      = 1550;
    localparam int MIN_FRAMES     = 12;
    // Frame slots for the single full-size frame and for the drain pause.
    localparam int BIG_FRAME_AT   = 6;
    localparam int PAUSE_AT       = 3;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Extra wait after the last predicted result has come out, as a wide margin.
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [55:0] SYNC_WORD  = 56'h4E41_5649_4149_FF;
    localparam logic [63:0] TAIL_WORD  = 64'h5445_4C45_4F50_544E;
    localparam logic [31:0] CASTAGNOLI = 32'h82F6_3B78;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_TAIL,
        FRAME_BAD_LEN,
        FRAME_BROKEN_SYNC
    } t_frame_flaw;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte        = 8'h00;
    logic [63:0] now_time       = 64'h0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [1:0]  frame_status;
    logic [7:0]  packet_kind;
    logic [15:0] packet_number;
    logic [15:0] fragment_count;
    logic [15:0] fragment_index;
    logic [63:0] sender_time;
    logic [31:0] crc_fail_total;

    // While calm is set neither side idles, which gives one long unbroken stretch.
    logic        calm           = 1'b0;
    int          pending;
    int          fail_count;
    int          idle_cycles    = 0;
    int          sent_bytes     = 0;
    int          frames         = 0;

    crc_checked_frame_deframer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_now_time       (now_time),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_kind       (out_kind),
        .o_payload_byte   (payload_byte),
        .o_frame_last     (frame_last),
        .o_frame_status   (frame_status),
        .o_packet_kind    (packet_kind),
        .o_packet_number  (packet_number),
        .o_fragment_count (fragment_count),
        .o_fragment_index (fragment_index),
        .o_sender_time    (sender_time),
        .o_crc_fail_total (crc_fail_total)
    );

    cfd_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_now_time       (now_time),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_kind       (out_kind),
        .i_payload_byte   (payload_byte),
        .i_frame_last     (frame_last),
        .i_frame_status   (frame_status),
        .i_packet_kind    (packet_kind),
        .i_packet_number  (packet_number),
        .i_fragment_count (fragment_count),
        .i_fragment_index (fragment_index),
        .i_sender_time    (sender_time),
        .i_crc_fail_total (crc_fail_total),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls in about a third of the cycles, except while calm.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 32);
    end

    // The watchdog restarts on every transfer in either direction. If it expires,
    // something got stuck, and the run ends as a failure.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one byte and returns at the edge where its transfer happens. The byte
    // may be preceded by a few idle cycles, and the payload only changes between
    // transfers, never while the block stalls it.
    task automatic send_byte(input logic [7:0] value, input logic [63:0] stamp);
        while (!calm && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        now_time <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Sends one frame with the given flaw. The current time is held for the whole
    // frame and is placed relative to the sender time so that the widening sees
    // near, halfway and wrapping cases, not only random ones.
    task automatic send_frame(input t_frame_flaw flaw, input int payload_len);
        logic [7:0]   body_q[$];
        logic [7:0]   value;
        logic [7:0]   kind;
        logic [15:0]  length;
        logic [31:0]  crc;
        logic [31:0]  stamp_low;
        logic [63:0]  stamp;
        logic [135:0] head;
        int           cut;
        int           bad_at;

        case ($urandom_range(0, 3))
            0:       stamp_low = 32'h0;
            1:       stamp_low = 32'hFFFF_FFFF;
            default: stamp_low = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       stamp = {$urandom, $urandom};
            1:       stamp = {$urandom, stamp_low + 32'($urandom_range(0, 2000)) - 32'd1000};
            2:       stamp = {$urandom, stamp_low ^ 32'h8000_0000};
            3:       stamp = {(($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF), $urandom};
            default: stamp = {$urandom, stamp_low + 32'h8000_0000
                                        + 32'($urandom_range(0, 2)) - 32'd1};
        endcase

        // A broken sync word stops short and then shows a byte that cannot continue it.
        cut = (flaw == FRAME_BROKEN_SYNC) ? $urandom_range(1, SYNC_LEN - 1) : SYNC_LEN;
        for (int k = 0; k < cut; k++)
            send_byte(SYNC_WORD[8 * (6 - k) +: 8], stamp);
        if (flaw == FRAME_BROKEN_SYNC) begin
            do
                value = 8'($urandom);
            while (value == SYNC_WORD[8 * (6 - cut) +: 8]);
            send_byte(value, stamp);
            return;
        end

        kind = 8'($urandom);
        if (flaw == FRAME_BAD_LEN) begin
            case ($urandom_range(0, 4))
                0:       length = 16'd0;
                1:       length = 16'(MIN_FRAME - 1);
                2:       length = MAX_FRAME + 16'd1;
                3:       length = 16'hFFFF;
                default: length = ($urandom_range(0, 1) != 0)
                                  ? 16'($urandom_range(0, MIN_FRAME - 1))
                                  : 16'($urandom_range(int'(MAX_FRAME) + 1, 65535));
            endcase
            send_byte(kind, stamp);
            send_byte(length[7:0], stamp);
            send_byte(length[15:8], stamp);
            return;
        end

        length = 16'(HEAD_LEN + TAIL_LEN + payload_len);
        crc    = 32'hFFFF_FFFF;
        for (int k = 0; k < payload_len; k++) begin
            value = 8'($urandom);
            body_q.insert(body_q.size(), value);
            crc = crc ^ {24'h0, value};
            repeat (8)
                crc = crc[0] ? (crc >> 1) ^ CASTAGNOLI : crc >> 1;
        end
        crc = ~crc;
        // Half of the bad-tail frames also carry a wrong CRC, so that the tail check
        // is seen to take precedence.
        if (flaw == FRAME_BAD_CRC || (flaw == FRAME_BAD_TAIL && $urandom_range(0, 1) != 0))
            crc = crc ^ (32'h1 << $urandom_range(0, 31));

        // Little-endian header after the sync word, type byte first.
        head = {crc, stamp_low, 16'($urandom), 16'($urandom), 16'($urandom), length, kind};
        for (int k = 0; k < HEAD_LEN - SYNC_LEN; k++)
            send_byte(head[8 * k +: 8], stamp);
        foreach (body_q[k])
            send_byte(body_q[k], stamp);

        bad_at = (flaw == FRAME_BAD_TAIL) ? $urandom_range(0, TAIL_LEN - 1) : TAIL_LEN;
        for (int k = 0; k < TAIL_LEN; k++) begin
            value = TAIL_WORD[8 * (7 - k) +: 8];
            if (k == bad_at)
                value = value ^ 8'($urandom_range(1, 255));
            send_byte(value, stamp);
        end
    endtask

    initial begin : stimulus
        int          pick;
        t_frame_flaw flaw;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // A sync word that breaks on its fourth byte with a fresh first sync byte,
        // which must count as the start of a new match. The frame that follows has
        // the largest possible length and is rejected on its length.
        send_byte(8'h4E, 64'h0);
        send_byte(8'h41, 64'h0);
        send_byte(8'h56, 64'h0);
        for (int k = 0; k < SYNC_LEN; k++)
            send_byte(SYNC_WORD[8 * (6 - k) +: 8], 64'h0);
        send_byte(8'hFF, 64'h0);
        send_byte(8'hFF, 64'h0);
        send_byte(8'hFF, 64'h0);

        // A length one below the minimum, at the largest current time.
        for (int k = 0; k < SYNC_LEN; k++)
            send_byte(SYNC_WORD[8 * (6 - k) +: 8], 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'(MIN_FRAME - 1), 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);

        // Mostly well-formed frames with short payloads, many flawed ones, noise in
        // between, the shortest legal frame first and one full-size frame sent with
        // no idling on either side.
        while (sent_bytes < ITEM_GOAL || frames < MIN_FRAMES) begin
            if (frames == 0) begin
                send_frame(FRAME_GOOD, 0);
            end else if (frames == BIG_FRAME_AT) begin
                calm <= 1'b1;
                send_frame(($urandom_range(0, 2) == 0) ? FRAME_BAD_CRC : FRAME_GOOD,
                           int'(MAX_FRAME) - HEAD_LEN - TAIL_LEN);
                calm <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                flaw = (pick < 55) ? FRAME_GOOD :
                       (pick < 68) ? FRAME_BAD_CRC :
                       (pick < 80) ? FRAME_BAD_TAIL :
                       (pick < 90) ? FRAME_BAD_LEN : FRAME_BROKEN_SYNC;
                send_frame(flaw, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
            end
            frames++;

            // Once, hold the sender back until every predicted result has come out.
            if (frames == PAUSE_AT) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end

            // Noise between frames, rich in first sync bytes.
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? 8'h4E : 8'($urandom),
                              {$urandom, $urandom});
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cfd_pkg.sv
hdl/cfd_crc_byte.sv
hdl/cfd_time_widen.sv
hdl/crc_checked_frame_deframer.sv
tb/cfd_result_checker.sv
tb/tb_crc_checked_frame_deframer.sv
